[hw/rtl/spq_pkg.sv]
// Shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;

    localparam int VALUE_W    = 32;
    localparam int IN_PRIO_W  = 8;
    localparam int OUT_PRIO_W = 8;
    localparam int FILL_W     = 5;
    localparam int STATUS_W   = 2;

    localparam logic FUNC_INSERT   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    localparam logic TIE_FIFO = 1'b0;
    localparam logic TIE_LIFO = 1'b1;

    localparam logic TIE_RESET = TIE_LIFO;

    localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

[hw/rtl/spq_ctrl.sv]
// Controller state machine that sequences the capture and execution of one command.
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_done
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;
    logic   w_accept;

    assign w_accept   = i_start && !r_busy;
    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_busy     = r_busy;
    assign o_done     = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state == S_EXEC))
        else $error("busy flag disagrees with controller state");
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_done && !r_busy)
        else $error("execution cycle not followed by a result beat");
    a_empty_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_stat.empty && i_stat.full))
        else $error("queue reported empty and full at once");
`endif

endmodule

[hw/rtl/spq_datapath.sv]
// Datapath holding the sorted entry cells, the tie mode register and the result registers.
module spq_datapath #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spq_pkg::t_dp_cmd                     i_cmd,
    output spq_pkg::t_dp_stat                    o_stat,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    input  logic                                i_func,
    input  logic signed [spq_pkg::VALUE_W-1:0]    i_item_value,
    input  logic [spq_pkg::IN_PRIO_W-1:0]         i_item_priority,
    output logic [spq_pkg::STATUS_W-1:0]          o_status,
    output logic signed [spq_pkg::VALUE_W-1:0]    o_out_value,
    output logic [spq_pkg::OUT_PRIO_W-1:0]        o_out_priority,
    output logic [spq_pkg::FILL_W-1:0]            o_fill_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic                                r_tie_mode;
    logic                                r_func;
    logic [spq_pkg::VALUE_W-1:0]         r_val;
    logic [PRIO_BITS-1:0]                r_pri;
    logic [spq_pkg::VALUE_W-1:0]         r_val_q [DEPTH];
    logic [PRIO_BITS-1:0]                r_pri_q [DEPTH];
    logic [CNT_W-1:0]                    r_count;
    logic [spq_pkg::STATUS_W-1:0]        r_status;
    logic [spq_pkg::VALUE_W-1:0]         r_out_value;
    logic [spq_pkg::OUT_PRIO_W-1:0]      r_out_pri;

    logic [PRIO_BITS+spq_pkg::IN_PRIO_W-1:0]  w_in_pri_ext;
    logic [spq_pkg::OUT_PRIO_W+PRIO_BITS-1:0] w_head_pri_ext;
    logic [spq_pkg::FILL_W+CNT_W-1:0]         w_fill_ext;
    logic [DEPTH-1:0]                         w_before;
    logic                                     w_full;
    logic                                     w_empty;
    logic                                     w_do_insert;
    logic                                     w_do_dispatch;

    assign w_in_pri_ext   = {{PRIO_BITS{1'b0}}, i_item_priority};
    assign w_head_pri_ext = {{spq_pkg::OUT_PRIO_W{1'b0}}, r_pri_q[0]};
    assign w_fill_ext     = {{spq_pkg::FILL_W{1'b0}}, r_count};

    assign w_full  = (r_count == CNT_FULL);
    assign w_empty = (r_count == '0);
    assign o_stat.full  = w_full;
    assign o_stat.empty = w_empty;

    assign w_do_insert   = i_cmd.exec && (r_func == spq_pkg::FUNC_INSERT) && !w_full;
    assign w_do_dispatch = i_cmd.exec && (r_func == spq_pkg::FUNC_DISPATCH) && !w_empty;

    // A cell stays in place on insert when its entry sorts ahead of the new one.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (r_tie_mode == spq_pkg::TIE_LIFO) begin
                w_before[i] = (CNT_W'(i) < r_count) && (r_pri_q[i] < r_pri);
            end else begin
                w_before[i] = (CNT_W'(i) < r_count) && (r_pri_q[i] <= r_pri);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_insert) begin
            if (!w_before[0]) begin
                r_val_q[0] <= r_val;
                r_pri_q[0] <= r_pri;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (!w_before[i]) begin
                    if (w_before[i-1]) begin
                        r_val_q[i] <= r_val;
                        r_pri_q[i] <= r_pri;
                    end else begin
                        r_val_q[i] <= r_val_q[i-1];
                        r_pri_q[i] <= r_pri_q[i-1];
                    end
                end
            end
        end else if (w_do_dispatch) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_val_q[i] <= r_val_q[i+1];
                r_pri_q[i] <= r_pri_q[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_val  <= i_item_value;
            r_pri  <= w_in_pri_ext[PRIO_BITS-1:0];
        end
        if (i_cmd.exec) begin
            r_out_value <= '0;
            r_out_pri   <= '0;
            if (r_func == spq_pkg::FUNC_INSERT) begin
                r_status <= w_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
            end else if (w_empty) begin
                r_status <= spq_pkg::ST_EMPTY;
            end else begin
                r_status    <= spq_pkg::ST_DISPATCHED;
                r_out_value <= r_val_q[0];
                r_out_pri   <= w_head_pri_ext[spq_pkg::OUT_PRIO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_tie_mode <= spq_pkg::TIE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_tie_mode <= i_cfg_data;
            end
            if (w_do_insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_dispatch) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_pri;
    assign o_fill_count   = w_fill_ext[spq_pkg::FILL_W-1:0];

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count exceeds queue depth");
    a_full_insert_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (r_func == spq_pkg::FUNC_INSERT) && w_full |=> $stable(r_count))
        else $error("dropped insert changed the entry count");
    a_empty_dispatch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (r_func == spq_pkg::FUNC_DISPATCH) && w_empty |=> $stable(r_count))
        else $error("dispatch from an empty queue changed the entry count");
`endif

endmodule

[hw/rtl/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: controller, datapath and configuration port.
//
//   channel   direction  handshake                    beat contents
//   command   in         i_start high, o_busy low     i_func, i_item_value, i_item_priority
//   result    out        o_done strobe, one cycle     o_status, o_out_value,
//                                                     o_out_priority, o_fill_count
//   config    in         i_cfg_valid and o_cfg_ready  i_cfg_data (tie mode)
//
// Each command is captured from the beat in S_IDLE and then updates the
// entry cells in S_EXEC, whose compare-and-shift acts on all cells at once.
// The result beat appears the cycle after execution, as o_busy drops, so a new
// command can be accepted in the same cycle that a result is presented.
// Reset is synchronous and active low; it empties the queue and sets tie mode to lifo.
// The receiver cannot stall results; the configuration port is always ready.
module sorted_priority_queue_unit #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_func,
    input  logic signed [spq_pkg::VALUE_W-1:0]   i_item_value,
    input  logic [spq_pkg::IN_PRIO_W-1:0]        i_item_priority,
    output logic                               o_done,
    output logic [spq_pkg::STATUS_W-1:0]         o_status,
    output logic signed [spq_pkg::VALUE_W-1:0]   o_out_value,
    output logic [spq_pkg::OUT_PRIO_W-1:0]       o_out_priority,
    output logic [spq_pkg::FILL_W-1:0]           o_fill_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);

    spq_pkg::t_dp_cmd  w_cmd;
    spq_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    spq_datapath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_fill_count    (o_fill_count)
    );

endmodule
